### hw/rtl/bps_pkg.sv
// ----------------------------------------------------------------------------
// Blinn-Phong shader package
// Shared payload types, register indexes and pipeline depths.
// ----------------------------------------------------------------------------
package bps_pkg;

   localparam int SQRT_STEPS = 32;
   localparam int QUO_BITS   = 15;
   localparam int UNIT_LAT   = SQRT_STEPS + QUO_BITS + 5;
   localparam int POW_STAGES = 255;

   localparam logic [15:0] INTENSITY_RESET = 16'd32768;
   localparam logic [7:0]  SPEC_POWER_RESET = 8'd8;
   localparam logic [47:0] AMBIENT_RESET   = 48'd429522944;
   localparam logic [47:0] DIFFUSE_RESET   = 48'd1073741824;
   localparam logic [47:0] SPECULAR_RESET  = 48'd70369817935872;

   typedef enum logic [2:0] {
      CSR_LIGHT_X    = 3'd0,
      CSR_LIGHT_Y    = 3'd1,
      CSR_LIGHT_Z    = 3'd2,
      CSR_INTENSITY  = 3'd3,
      CSR_SPEC_POWER = 3'd4,
      CSR_AMBIENT    = 3'd5,
      CSR_DIFFUSE    = 3'd6,
      CSR_SPECULAR   = 3'd7
   } csr_index_type;

   typedef struct packed {
      logic signed [23:0] pos_x;
      logic signed [23:0] pos_y;
      logic signed [23:0] pos_z;
      logic signed [15:0] normal_x;
      logic signed [15:0] normal_y;
      logic signed [15:0] normal_z;
   } req_type;

   typedef struct packed {
      logic [15:0] red;
      logic [15:0] green;
      logic [15:0] blue;
   } rsp_type;

   typedef struct packed {
      logic signed [15:0] x;
      logic signed [15:0] y;
      logic signed [15:0] z;
   } nvec_type;

   typedef struct packed {
      logic               valid;
      logic signed [25:0] x;
      logic signed [25:0] y;
      logic signed [25:0] z;
   } uvec_in_type;

   typedef struct packed {
      logic     valid;
      nvec_type v;
   } uvec_out_type;

endpackage

### hw/rtl/bps_unitize.sv
// ----------------------------------------------------------------------------
// Vector normalizer
// Pipelined unit vector in Q1.14: squares, bit-per-stage square root,
// bit-per-stage division of each component by the length.
// ----------------------------------------------------------------------------
module bps_unitize import bps_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  uvec_in_type  vec_in,
   output uvec_out_type vec_out
);

   typedef struct packed {
      logic             valid;
      logic [2:0]       neg;
      logic [2:0][24:0] mag;
   } mag_type;

   typedef struct packed {
      logic             valid;
      logic             zero;
      logic [2:0]       neg;
      logic [2:0][24:0] mag;
      logic [63:0]      x;
      logic [63:0]      r;
   } root_type;

   typedef struct packed {
      logic             valid;
      logic             zero;
      logic [2:0]       neg;
      logic [31:0]      s;
      logic [2:0][46:0] rem;
      logic [2:0][14:0] q;
   } quo_type;

   logic signed [25:0] comp [3];
   logic [25:0]        abs_v [3];
   mag_type            a_in, a_ff, b_ff;
   logic [2:0][49:0]   sq_in, sq_ff;
   logic [51:0]        sum_v;
   root_type           root_in;
   root_type           root_ff [0:SQRT_STEPS];
   quo_type            quo_in;
   quo_type            quo_ff [0:QUO_BITS];
   uvec_out_type       out_in, out_ff;
   logic [15:0]        qe [3];
   logic signed [15:0] uo [3];

   assign comp[0] = vec_in.x;
   assign comp[1] = vec_in.y;
   assign comp[2] = vec_in.z;

   always_comb begin
      a_in.valid = vec_in.valid;
      for (int i = 0; i < 3; i++) begin
         abs_v[i] = comp[i][25] ? 26'(-comp[i]) : comp[i];
         a_in.neg[i] = comp[i][25];
         a_in.mag[i] = abs_v[i][24:0];
      end
   end

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         sq_in[i] = a_ff.mag[i] * a_ff.mag[i];
      end
   end

   always_comb begin
      sum_v = 52'(sq_ff[0]) + 52'(sq_ff[1]) + 52'(sq_ff[2]);
      root_in.valid = b_ff.valid;
      root_in.zero = (sum_v == 52'd0);
      root_in.neg = b_ff.neg;
      root_in.mag = b_ff.mag;
      root_in.x = {sum_v, 12'd0};
      root_in.r = 64'd0;
   end

   always_ff @(posedge clock) begin
      sq_ff <= sq_in;
      if (reset) begin
         a_ff.valid <= 1'b0;
         b_ff.valid <= 1'b0;
         root_ff[0].valid <= 1'b0;
      end else begin
         a_ff <= a_in;
         b_ff <= a_ff;
         root_ff[0] <= root_in;
      end
   end

   for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_root
      localparam logic [63:0] BIT = 64'd1 << (62 - 2 * k);
      logic [64:0] trial;
      root_type    nxt;

      always_comb begin
         trial = {1'b0, root_ff[k].r} + {1'b0, BIT};
         nxt = root_ff[k];
         if ({1'b0, root_ff[k].x} >= trial) begin
            nxt.x = root_ff[k].x - trial[63:0];
            nxt.r = (root_ff[k].r >> 1) + BIT;
         end else begin
            nxt.r = root_ff[k].r >> 1;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            root_ff[k + 1].valid <= 1'b0;
         end else begin
            root_ff[k + 1] <= nxt;
         end
      end
   end

   always_comb begin
      quo_in.valid = root_ff[SQRT_STEPS].valid;
      quo_in.zero = root_ff[SQRT_STEPS].zero;
      quo_in.neg = root_ff[SQRT_STEPS].neg;
      quo_in.s = root_ff[SQRT_STEPS].r[31:0];
      for (int i = 0; i < 3; i++) begin
         quo_in.rem[i] = {2'b00, root_ff[SQRT_STEPS].mag[i], 20'd0};
         quo_in.q[i] = 15'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         quo_ff[0].valid <= 1'b0;
      end else begin
         quo_ff[0] <= quo_in;
      end
   end

   for (genvar k = 0; k < QUO_BITS; k++) begin : g_quo
      localparam int SH = QUO_BITS - 1 - k;
      logic [46:0] dvs;
      quo_type     nxt;

      always_comb begin
         dvs = 47'(quo_ff[k].s) << SH;
         nxt = quo_ff[k];
         for (int i = 0; i < 3; i++) begin
            if (quo_ff[k].rem[i] >= dvs) begin
               nxt.rem[i] = quo_ff[k].rem[i] - dvs;
               nxt.q[i][SH] = 1'b1;
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            quo_ff[k + 1].valid <= 1'b0;
         end else begin
            quo_ff[k + 1] <= nxt;
         end
      end
   end

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         qe[i] = {1'b0, quo_ff[QUO_BITS].q[i]};
         if (quo_ff[QUO_BITS].zero) begin
            uo[i] = 16'sd0;
         end else if (quo_ff[QUO_BITS].neg[i]) begin
            uo[i] = 16'(-qe[i]);
         end else begin
            uo[i] = qe[i];
         end
      end
      out_in.valid = quo_ff[QUO_BITS].valid;
      out_in.v.x = uo[0];
      out_in.v.y = uo[1];
      out_in.v.z = uo[2];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_ff.valid <= 1'b0;
      end else begin
         out_ff <= out_in;
      end
   end

   assign vec_out = out_ff;

endmodule

### hw/rtl/blinn_phong_fragment_shader.sv
// ----------------------------------------------------------------------------
// Blinn-Phong fragment shader
// Fixed-point Blinn-Phong color for one fragment per clock, eye at origin.
// ----------------------------------------------------------------------------
// Requests enter on req_data when start is high and busy is low; busy is
// high only while reset is asserted, so a request may enter every cycle.
// Each request gives one color on rsp_data, marked by rsp_strobe for one
// cycle, in request order. Throughput is one request per cycle. The
// pipeline depth is set by the three normalizers (two in parallel then
// one, each a 32-stage square root and a 15-stage divider) and the
// 255-stage specular power chain, one multiply per stage.
// Registers are written through csr_we, csr_index and csr_data with no
// wait; write them only while no request is in flight.
// Synchronous reset clears the pipeline valid bits and restores register
// defaults. The receiver cannot stall: the pipeline never holds.
// ----------------------------------------------------------------------------
module blinn_phong_fragment_shader import bps_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  req_type     req_data,
   output logic        rsp_strobe,
   output rsp_type     rsp_data,
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [47:0] csr_data
);

   typedef struct packed {
      nvec_type n;
      nvec_type l;
   } pair_type;

   typedef struct packed {
      logic        valid;
      logic [15:0] nl;
      logic [15:0] nh;
      logic [15:0] r;
   } pow_type;

   typedef struct packed {
      logic        valid;
      logic [15:0] nl;
      logic [15:0] nh;
      logic [15:0] td;
      logic [15:0] ts;
   } scale_type;

   typedef struct packed {
      logic             valid;
      logic [2:0][16:0] dterm;
      logic [2:0][16:0] sterm;
   } term_type;

   logic signed [23:0] light_x_ff, light_y_ff, light_z_ff;
   logic [15:0]        intensity_ff;
   logic [7:0]         spec_power_ff;
   logic [47:0]        ambient_ff, diffuse_ff, specular_ff;

   uvec_in_type        lv_in, lv_ff, ev_in, ev_ff, hv;
   nvec_type           norm_ff;
   uvec_out_type       lu, eu, hu;
   nvec_type           nd_ff [0:UNIT_LAT-1];
   pair_type           hd_ff [0:UNIT_LAT-1];
   logic               p1_valid_ff;
   logic signed [31:0] pl_ff [3];
   logic signed [31:0] ph_ff [3];
   pow_type            pow_in;
   pow_type            pow_ff [0:POW_STAGES];
   scale_type          sc_in, sc_ff;
   term_type           tm_in, tm_ff;
   rsp_type            out_in, out_ff;
   logic               out_valid_ff;
   logic [18:0]        chan [3];
   logic [15:0]        chan_sat [3];
   logic [31:0]        pd, ps;

   function automatic logic [15:0] factor(input logic signed [33:0] d);
      logic [19:0] f;
      f = d[33:14];
      if (d <= 34'sd0) begin
         return 16'd0;
      end
      if (f > 20'd16384) begin
         f = 20'd16384;
      end
      return {f[14:0], 1'b0};
   endfunction

   function automatic logic signed [25:0] sx24(input logic signed [23:0] a);
      return {{2{a[23]}}, a};
   endfunction

   function automatic logic signed [25:0] sx16(input logic signed [15:0] a);
      return {{10{a[15]}}, a};
   endfunction

   function automatic logic signed [33:0] sx32(input logic signed [31:0] a);
      return {{2{a[31]}}, a};
   endfunction

   assign busy = reset;

   always_ff @(posedge clock) begin
      if (reset) begin
         light_x_ff <= 24'sd0;
         light_y_ff <= 24'sd0;
         light_z_ff <= 24'sd0;
         intensity_ff <= INTENSITY_RESET;
         spec_power_ff <= SPEC_POWER_RESET;
         ambient_ff <= AMBIENT_RESET;
         diffuse_ff <= DIFFUSE_RESET;
         specular_ff <= SPECULAR_RESET;
      end else if (csr_we) begin
         case (csr_index_type'(csr_index))
            CSR_LIGHT_X: begin
               light_x_ff <= csr_data[23:0];
            end
            CSR_LIGHT_Y: begin
               light_y_ff <= csr_data[23:0];
            end
            CSR_LIGHT_Z: begin
               light_z_ff <= csr_data[23:0];
            end
            CSR_INTENSITY: begin
               intensity_ff <= csr_data[15:0];
            end
            CSR_SPEC_POWER: begin
               spec_power_ff <= csr_data[7:0];
            end
            CSR_AMBIENT: begin
               ambient_ff <= csr_data;
            end
            CSR_DIFFUSE: begin
               diffuse_ff <= csr_data;
            end
            CSR_SPECULAR: begin
               specular_ff <= csr_data;
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      lv_in.valid = start & ~busy;
      lv_in.x = sx24(light_x_ff) - sx24(req_data.pos_x);
      lv_in.y = sx24(light_y_ff) - sx24(req_data.pos_y);
      lv_in.z = sx24(light_z_ff) - sx24(req_data.pos_z);
      ev_in.valid = start & ~busy;
      ev_in.x = 26'sd0 - sx24(req_data.pos_x);
      ev_in.y = 26'sd0 - sx24(req_data.pos_y);
      ev_in.z = 26'sd0 - sx24(req_data.pos_z);
   end

   always_ff @(posedge clock) begin
      norm_ff.x <= req_data.normal_x;
      norm_ff.y <= req_data.normal_y;
      norm_ff.z <= req_data.normal_z;
      if (reset) begin
         lv_ff.valid <= 1'b0;
         ev_ff.valid <= 1'b0;
      end else begin
         lv_ff <= lv_in;
         ev_ff <= ev_in;
      end
   end

   bps_unitize u_unit_l (
      .clock   (clock),
      .reset   (reset),
      .vec_in  (lv_ff),
      .vec_out (lu)
   );

   bps_unitize u_unit_e (
      .clock   (clock),
      .reset   (reset),
      .vec_in  (ev_ff),
      .vec_out (eu)
   );

   always_comb begin
      hv.valid = lu.valid;
      hv.x = sx16(lu.v.x) + sx16(eu.v.x);
      hv.y = sx16(lu.v.y) + sx16(eu.v.y);
      hv.z = sx16(lu.v.z) + sx16(eu.v.z);
   end

   bps_unitize u_unit_h (
      .clock   (clock),
      .reset   (reset),
      .vec_in  (hv),
      .vec_out (hu)
   );

   always_ff @(posedge clock) begin
      nd_ff[0] <= norm_ff;
      hd_ff[0] <= {nd_ff[UNIT_LAT-1], lu.v};
      for (int j = 1; j < UNIT_LAT; j++) begin
         nd_ff[j] <= nd_ff[j-1];
         hd_ff[j] <= hd_ff[j-1];
      end
   end

   always_ff @(posedge clock) begin
      pl_ff[0] <= hd_ff[UNIT_LAT-1].n.x * hd_ff[UNIT_LAT-1].l.x;
      pl_ff[1] <= hd_ff[UNIT_LAT-1].n.y * hd_ff[UNIT_LAT-1].l.y;
      pl_ff[2] <= hd_ff[UNIT_LAT-1].n.z * hd_ff[UNIT_LAT-1].l.z;
      ph_ff[0] <= hd_ff[UNIT_LAT-1].n.x * hu.v.x;
      ph_ff[1] <= hd_ff[UNIT_LAT-1].n.y * hu.v.y;
      ph_ff[2] <= hd_ff[UNIT_LAT-1].n.z * hu.v.z;
      if (reset) begin
         p1_valid_ff <= 1'b0;
      end else begin
         p1_valid_ff <= hu.valid;
      end
   end

   always_comb begin
      pow_in.valid = p1_valid_ff;
      pow_in.nl = factor(sx32(pl_ff[0]) + sx32(pl_ff[1]) + sx32(pl_ff[2]));
      pow_in.nh = factor(sx32(ph_ff[0]) + sx32(ph_ff[1]) + sx32(ph_ff[2]));
      pow_in.r = 16'd32768;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pow_ff[0].valid <= 1'b0;
      end else begin
         pow_ff[0] <= pow_in;
      end
   end

   for (genvar k = 0; k < POW_STAGES; k++) begin : g_pow
      localparam logic [7:0] IDX = 8'(k);
      logic [31:0] prod;
      pow_type     nxt;

      always_comb begin
         prod = pow_ff[k].r * pow_ff[k].nh;
         nxt = pow_ff[k];
         if (spec_power_ff > IDX) begin
            nxt.r = prod[30:15];
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            pow_ff[k + 1].valid <= 1'b0;
         end else begin
            pow_ff[k + 1] <= nxt;
         end
      end
   end

   always_comb begin
      pd = intensity_ff * pow_ff[POW_STAGES].nl;
      ps = intensity_ff * pow_ff[POW_STAGES].r;
      sc_in.valid = pow_ff[POW_STAGES].valid;
      sc_in.nl = pow_ff[POW_STAGES].nl;
      sc_in.nh = pow_ff[POW_STAGES].nh;
      sc_in.td = pd[30:15];
      sc_in.ts = ps[30:15];
   end

   always_comb begin
      logic [31:0] dp [3];
      logic [31:0] sp [3];
      tm_in.valid = sc_ff.valid;
      for (int i = 0; i < 3; i++) begin
         dp[i] = diffuse_ff[16*i +: 16] * sc_ff.td;
         sp[i] = specular_ff[16*i +: 16] * sc_ff.ts;
         tm_in.dterm[i] = (sc_ff.nl != 16'd0) ? dp[i][31:15] : 17'd0;
         tm_in.sterm[i] = (sc_ff.nh != 16'd0) ? sp[i][31:15] : 17'd0;
      end
   end

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         chan[i] = 19'(ambient_ff[16*i +: 16]) + 19'(tm_ff.dterm[i])
                 + 19'(tm_ff.sterm[i]);
         chan_sat[i] = (chan[i] > 19'd65535) ? 16'hFFFF : chan[i][15:0];
      end
      out_in.red = chan_sat[0];
      out_in.green = chan_sat[1];
      out_in.blue = chan_sat[2];
   end

   always_ff @(posedge clock) begin
      out_ff <= out_in;
      if (reset) begin
         sc_ff.valid <= 1'b0;
         tm_ff.valid <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         sc_ff <= sc_in;
         tm_ff <= tm_in;
         out_valid_ff <= tm_ff.valid;
      end
   end

   assign rsp_strobe = out_valid_ff;
   assign rsp_data = out_ff;

endmodule

### verif/tb_blinn_phong_fragment_shader.sv
// ----------------------------------------------------------------------------
// Blinn-Phong fragment shader testbench
// Drives fragments through the shader under a series of light and material
// settings, predicts each shaded color in fixed point and checks every color
// strobe against the oldest prediction. Covers extreme positions and normals,
// the degenerate unit vectors, a zero exponent and random fragments aimed at
// the light and halfway directions.
// ----------------------------------------------------------------------------
module tb_blinn_phong_fragment_shader;
   import bps_pkg::*;

   localparam int IDLE_LIMIT = 4000;
   localparam int TAIL_ITEMS = 200;

   typedef struct packed {
      logic signed [23:0] lx;
      logic signed [23:0] ly;
      logic signed [23:0] lz;
      logic [15:0]        inten;
      logic [7:0]         power;
      logic [47:0]        amb;
      logic [47:0]        dif;
      logic [47:0]        spc;
   } shade_cfg_type;

   typedef struct packed {
      logic signed [63:0] x;
      logic signed [63:0] y;
      logic signed [63:0] z;
   } vec3_type;

   typedef struct packed {
      logic          is_csr;
      csr_index_type idx;
      logic [47:0]   wdata;
      req_type       frag;
   } plan_entry_type;

   logic          clock = 1'b0;
   logic          reset = 1'b1;
   logic          start = 1'b0;
   logic          busy;
   req_type       req_data = '0;
   logic          rsp_strobe;
   rsp_type       rsp_data;
   logic          csr_we = 1'b0;
   logic [2:0]    csr_index = '0;
   logic [47:0]   csr_data = '0;

   plan_entry_type plan_q[$];
   rsp_type        colors_due[$];
   shade_cfg_type  cfg_live;
   shade_cfg_type  cfg_plan;
   logic           req_taken = 1'b0;
   int             gap = 0;
   int             n_errors = 0;
   int             n_planned = 0;
   int             n_taken = 0;
   int             n_colors = 0;
   int             n_writes = 0;
   int             idle_cycles = 0;

   blinn_phong_fragment_shader i_dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always #5 clock = ~clock;

   function automatic logic [63:0] isqrt(logic [63:0] x);
      logic [63:0] r;
      logic [63:0] b;
      r = 0;
      b = 64'd1 << 62;
      while (b > x) b = b >> 2;
      while (b != 0) begin
         if (x >= r + b) begin
            x = x - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   function automatic logic signed [63:0] unit_comp(logic signed [63:0] c,
                                                    logic [63:0] s);
      logic [63:0]        m;
      logic signed [63:0] q;
      m = (c < 0) ? -c : c;
      q = (m << 20) / s;
      return (c < 0) ? -q : q;
   endfunction

   function automatic vec3_type unitize(vec3_type v);
      logic [63:0] len2;
      logic [63:0] s;
      vec3_type    u;
      len2 = v.x * v.x + v.y * v.y + v.z * v.z;
      if (len2 == 0) return '0;
      s = isqrt(len2 << 12);
      u.x = unit_comp(v.x, s);
      u.y = unit_comp(v.y, s);
      u.z = unit_comp(v.z, s);
      return u;
   endfunction

   function automatic logic [63:0] dot_factor(vec3_type n, vec3_type u);
      logic signed [63:0] d;
      logic [63:0]        f;
      d = n.x * u.x + n.y * u.y + n.z * u.z;
      if (d <= 0) return 0;
      f = d >>> 14;
      if (f > 16384) f = 16384;
      return f << 1;
   endfunction

   // light and halfway unit vectors seen from one fragment
   function automatic void light_dirs(req_type r, shade_cfg_type c,
                                      output vec3_type lu, output vec3_type hu);
      vec3_type lv;
      vec3_type ev;
      vec3_type eu;
      vec3_type hv;
      lv.x = 64'(c.lx) - 64'(r.pos_x);
      lv.y = 64'(c.ly) - 64'(r.pos_y);
      lv.z = 64'(c.lz) - 64'(r.pos_z);
      ev.x = -64'(r.pos_x);
      ev.y = -64'(r.pos_y);
      ev.z = -64'(r.pos_z);
      lu = unitize(lv);
      eu = unitize(ev);
      hv.x = lu.x + eu.x;
      hv.y = lu.y + eu.y;
      hv.z = lu.z + eu.z;
      hu = unitize(hv);
   endfunction

   function automatic rsp_type shade_color(req_type r, shade_cfg_type c);
      vec3_type    n;
      vec3_type    lu;
      vec3_type    hu;
      logic [63:0] nl;
      logic [63:0] nh;
      logic [63:0] pw;
      logic [63:0] td;
      logic [63:0] ts;
      logic [63:0] ch;
      logic [15:0] chan [3];
      rsp_type     o;
      n.x = 64'(r.normal_x);
      n.y = 64'(r.normal_y);
      n.z = 64'(r.normal_z);
      light_dirs(r, c, lu, hu);
      nl = dot_factor(n, lu);
      nh = dot_factor(n, hu);
      pw = 32768;
      for (int k = 0; k < c.power; k++) pw = (pw * nh) >> 15;
      td = (64'(c.inten) * nl) >> 15;
      ts = (64'(c.inten) * pw) >> 15;
      for (int i = 0; i < 3; i++) begin
         ch = 64'(c.amb[16*i +: 16]);
         if (nl > 0) ch = ch + ((64'(c.dif[16*i +: 16]) * td) >> 15);
         if (nh > 0) ch = ch + ((64'(c.spc[16*i +: 16]) * ts) >> 15);
         chan[i] = (ch > 65535) ? 16'hFFFF : ch[15:0];
      end
      o.red   = chan[0];
      o.green = chan[1];
      o.blue  = chan[2];
      return o;
   endfunction

   function automatic shade_cfg_type apply_write(shade_cfg_type c, csr_index_type idx,
                                                 logic [47:0] d);
      case (idx)
         CSR_LIGHT_X:    c.lx    = d[23:0];
         CSR_LIGHT_Y:    c.ly    = d[23:0];
         CSR_LIGHT_Z:    c.lz    = d[23:0];
         CSR_INTENSITY:  c.inten = d[15:0];
         CSR_SPEC_POWER: c.power = d[7:0];
         CSR_AMBIENT:    c.amb   = d;
         CSR_DIFFUSE:    c.dif   = d;
         CSR_SPECULAR:   c.spc   = d;
         default: ;
      endcase
      return c;
   endfunction

   function automatic shade_cfg_type reset_cfg();
      shade_cfg_type c;
      c.lx    = '0;
      c.ly    = '0;
      c.lz    = '0;
      c.inten = INTENSITY_RESET;
      c.power = SPEC_POWER_RESET;
      c.amb   = AMBIENT_RESET;
      c.dif   = DIFFUSE_RESET;
      c.spc   = SPECULAR_RESET;
      return c;
   endfunction

   task automatic queue_write(csr_index_type idx, logic [47:0] d);
      plan_entry_type e;
      e = '0;
      e.is_csr = 1'b1;
      e.idx    = idx;
      e.wdata  = d;
      plan_q = {plan_q, e};
      cfg_plan = apply_write(cfg_plan, idx, d);
   endtask

   task automatic queue_frag(logic [23:0] px, logic [23:0] py, logic [23:0] pz,
                             logic [15:0] nx, logic [15:0] ny, logic [15:0] nz);
      plan_entry_type e;
      e = '0;
      e.frag = {px, py, pz, nx, ny, nz};
      plan_q = {plan_q, e};
      n_planned++;
   endtask

   function automatic logic [15:0] clamp16(logic signed [63:0] v);
      if (v > 32767) return 16'sd32767;
      if (v < -32768) return 16'h8000;
      return v[15:0];
   endfunction

   function automatic logic [23:0] rand_pos();
      logic [23:0] v;
      v = 24'($urandom);
      if ($urandom_range(0, 1) == 0) v = 24'($signed(17'($urandom)));
      return v;
   endfunction

   task automatic queue_random_frag();
      req_type     r;
      vec3_type    lu;
      vec3_type    hu;
      vec3_type    d;
      int          pick;
      r = '0;
      r.pos_x = rand_pos();
      r.pos_y = rand_pos();
      r.pos_z = rand_pos();
      pick = $urandom_range(0, 9);
      light_dirs(r, cfg_plan, lu, hu);
      if (pick < 4) d = hu;
      else if (pick < 6) d = lu;
      else d = '0;
      if (pick < 6) begin
         r.normal_x = clamp16(d.x + $signed(6'($urandom)));
         r.normal_y = clamp16(d.y + $signed(6'($urandom)));
         r.normal_z = clamp16(d.z + $signed(6'($urandom)));
      end else if (pick < 9) begin
         r.normal_x = 16'($urandom_range(0, 32768) - 16384);
         r.normal_y = 16'($urandom_range(0, 32768) - 16384);
         r.normal_z = 16'($urandom_range(0, 32768) - 16384);
      end else begin
         r.normal_x = 16'($urandom);
         r.normal_y = 16'($urandom);
         r.normal_z = 16'($urandom);
      end
      queue_frag(r.pos_x, r.pos_y, r.pos_z, r.normal_x, r.normal_y, r.normal_z);
   endtask

   task automatic report_mismatch(string what, logic [15:0] got, logic [15:0] want);
      $display("%0t: %s mismatch: got %h, want %h", $realtime, what, got, want);
      n_errors++;
   endtask

   // driver: requests and register writes at the falling edge
   always @(negedge clock) begin
      logic        nxt_start;
      logic        nxt_we;
      req_type     nxt_data;
      logic [2:0]  nxt_idx;
      logic [47:0] nxt_wdata;
      nxt_start = start;
      nxt_we    = 1'b0;
      nxt_data  = req_data;
      nxt_idx   = csr_index;
      nxt_wdata = csr_data;
      if (!reset) begin
         if (start && req_taken) nxt_start = 1'b0;
         if (!nxt_start) begin
            if (gap > 0) begin
               gap--;
            end else if (plan_q.size() > 0) begin
               if (plan_q[0].is_csr) begin
                  if (colors_due.size() == 0 && !start) begin
                     nxt_we    = 1'b1;
                     nxt_idx   = plan_q[0].idx;
                     nxt_wdata = plan_q[0].wdata;
                     void'(plan_q.pop_front());
                  end
               end else begin
                  nxt_start = 1'b1;
                  nxt_data  = plan_q[0].frag;
                  void'(plan_q.pop_front());
                  if (plan_q.size() > TAIL_ITEMS && $urandom_range(0, 3) == 0)
                     gap = $urandom_range(1, 5);
               end
            end
         end
      end
      start     <= nxt_start;
      csr_we    <= nxt_we;
      req_data  <= nxt_data;
      csr_index <= nxt_idx;
      csr_data  <= nxt_wdata;
   end

   // monitor: predict on accept, check each color strobe
   always @(posedge clock) begin
      rsp_type want;
      req_taken = 1'b0;
      if (reset) begin
         cfg_live = reset_cfg();
      end else begin
         idle_cycles++;
         if (csr_we) begin
            cfg_live = apply_write(cfg_live, csr_index_type'(csr_index), csr_data);
            n_writes++;
            idle_cycles = 0;
         end
         if (start && !busy) begin
            req_taken = 1'b1;
            colors_due = {colors_due, shade_color(req_data, cfg_live)};
            n_taken++;
            idle_cycles = 0;
         end
         if (rsp_strobe) begin
            idle_cycles = 0;
            n_colors++;
            if (colors_due.size() == 0) begin
               $display("%0t: color %h with no request pending", $realtime, rsp_data);
               n_errors++;
            end else begin
               want = colors_due.pop_front();
               if (rsp_data.red !== want.red) report_mismatch("red", rsp_data.red, want.red);
               if (rsp_data.green !== want.green)
                  report_mismatch("green", rsp_data.green, want.green);
               if (rsp_data.blue !== want.blue)
                  report_mismatch("blue", rsp_data.blue, want.blue);
            end
         end
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("Timeout after %0d idle cycles", idle_cycles);
            $display("Some tests failed");
            $finish;
         end
      end
   end

   initial begin
      cfg_plan = reset_cfg();
      // reset settings: extremes, origin, light on the fragment
      queue_frag(24'h0, 24'h0, 24'h0, 16'sd16384, 16'sd0, 16'sd0);
      queue_frag(24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 16'sd16384, 16'sd16384, 16'sd16384);
      queue_frag(24'h800000, 24'h800000, 24'h800000, -16'sd16384, -16'sd16384, -16'sd16384);
      queue_frag(24'h7FFFFF, 24'h800000, 24'h0, 16'h7FFF, 16'h8000, 16'h7FFF);
      queue_frag(24'h0, 24'h0, -24'sd4096, 16'sd0, 16'sd0, 16'sd16384);
      queue_frag(24'h0, 24'h0, -24'sd4096, 16'h7FFF, 16'h7FFF, 16'h7FFF);
      queue_frag(24'h0, 24'h0, -24'sd4096, 16'h8000, 16'h8000, 16'h8000);
      queue_frag(24'sd4096, -24'sd4096, -24'sd8192, -16'sd16384, 16'sd0, 16'sd0);
      queue_frag(24'h1, 24'h0, 24'h0, -16'sd16384, 16'sd0, 16'sd0);
      queue_frag(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 16'sd9459, 16'sd9459, 16'sd9459);
      // halfway vector collapses: light straight behind the fragment from the eye
      queue_write(CSR_LIGHT_X, 48'd8192);
      queue_frag(24'sd4096, 24'h0, 24'h0, -16'sd16384, 16'sd0, 16'sd0);
      queue_frag(24'sd4096, 24'h0, 24'h0, 16'sd16384, 16'sd0, 16'sd0);
      queue_frag(24'sd8192, 24'h0, 24'h0, 16'sd16384, 16'sd0, 16'sd0);
      // zero exponent
      queue_write(CSR_SPEC_POWER, 48'd0);
      queue_write(CSR_LIGHT_Z, 48'd8192);
      queue_frag(24'h0, 24'h0, -24'sd4096, 16'sd0, 16'sd0, 16'sd16384);
      queue_frag(24'h0, 24'h0, -24'sd4096, 16'sd0, 16'sd16384, 16'sd0);
      queue_frag(24'sd100, -24'sd300, -24'sd4096, 16'sd0, 16'sd11585, 16'sd11585);
      for (int ph = 0; ph < 8; ph++) begin
         for (int i = 0; i < 8; i++) begin
            logic [47:0] v;
            v = 48'({$urandom, $urandom});
            if (ph == 0) v = '1;
            else if (ph == 1) v = '0;
            else if (i < 3 && $urandom_range(0, 1) == 0) v = 48'($signed(18'($urandom)));
            if (ph == 2 && i == 4) v = 48'd1;
            if (ph == 3 && i == 4) v = 48'd255;
            if (ph > 3 && i == 4) v = 48'($urandom_range(1, 40));
            if (ph == 1 && i == 5) v = '0;
            queue_write(csr_index_type'(i), v);
         end
         for (int k = 0; k < 250; k++) queue_random_frag();
      end
      while (reset !== 1'b0 || plan_q.size() > 0 || start || colors_due.size() > 0)
         @(posedge clock);
      repeat (400) @(posedge clock);
      $display("Shaded %0d of %0d fragments under %0d register writes, %0d colors checked",
               n_taken, n_planned, n_writes, n_colors);
      $display("Settings ranged from all-zero to all-ones, exponent 0 to 255");
      if (n_errors == 0 && colors_due.size() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

   initial begin
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
   end

endmodule
